// ===== rtl/pairwise_cosine_top_three_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise cosine top-three block
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_COSINE_TOP_THREE_TOP_MACROS_SVH
`define PAIRWISE_COSINE_TOP_THREE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcst assertion failed");
// next-cycle implication
`define PCST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcst assertion failed");
`else
`define PCST_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PCST_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/pcst_pkg.sv =====
// ----------------------------------------------------------------------------
// pcst_pkg
// Types and constants shared by the pairwise cosine top-three block.
// ----------------------------------------------------------------------------
package pcst_pkg;

  localparam int ELEMENT_BITS       = 16;
  localparam int DEF_MAX_VECTORS    = 256;
  localparam int DEF_MAX_DIMENSIONS = 128;
  localparam int TOP_COUNT          = 3;
  localparam int INDEX_BITS         = 8;
  localparam int SIM_BITS           = 16;
  localparam int SIM_MAX            = 32767;
  // cosine scaled by 2^15, squared and doubled for the rounding test
  localparam int FRAC_SHIFT         = 32;
  localparam int QUOT_BITS          = 33;
  localparam int ROOT_BITS          = 17;

  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic                           vector_end;
    logic                           set_end;
  } item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]      first_vector;
    logic [INDEX_BITS-1:0]      second_vector;
    logic signed [SIM_BITS-1:0] similarity;
    logic                       pair_found;
    logic                       last_result;
  } result_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FILL,
    S_PAIR_INIT,
    S_RD_I,
    S_RD_J,
    S_CAP,
    S_DOT,
    S_MUL_MAG,
    S_MUL_NORM,
    S_DIV,
    S_SQRT,
    S_OFFER,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/pcst_ram.sv =====
// ----------------------------------------------------------------------------
// pcst_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pairwise_cosine_top_three_top.sv =====
// ----------------------------------------------------------------------------
// pairwise_cosine_top_three_top
// Loads a set of vectors, scores every pair by cosine similarity and reports
// the three best pairs in descending order.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  request  | start, busy          | item   (element, vector/set end)
//  result   | strobe (one cycle)   | result (pair, similarity, flags)
//
// Loading takes one element per cycle while busy is low. Each vector end
// raises busy while missing components are zero filled and the norm stored.
// Each pair runs a one-element-per-cycle dot product over two copies of the
// vector RAM, then bit-serial multiply, divide and square-root units; a pair
// with a zero-norm vector skips these units.
// Results follow one per cycle; the receiver cannot stall.
// Reset clears control only; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
`include "pairwise_cosine_top_three_top_macros.svh"

module pairwise_cosine_top_three_top
  import pcst_pkg::*;
#(
  parameter int MAX_VECTORS    = DEF_MAX_VECTORS,
  parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  localparam int DW    = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int IW    = $clog2(MAX_VECTORS);
  localparam int PW    = $clog2(MAX_DIMENSIONS + 1);
  localparam int CW    = $clog2(MAX_VECTORS + 1);
  localparam int AW    = IW + DW;
  localparam int VDEP  = 1 << AW;
  localparam int SQW   = 2 * ELEMENT_BITS - 1;
  localparam int NW    = SQW + $clog2(MAX_DIMENSIONS);
  localparam int ACCW  = NW + 1;
  localparam int PRW   = 2 * NW;
  localparam int RW    = PRW + FRAC_SHIFT;
  localparam int MCW   = $clog2(NW);
  localparam int QCW   = $clog2(QUOT_BITS);
  localparam int KW    = $clog2(TOP_COUNT);

  state_t state, state_next;

  // loading state
  logic [CW-1:0] vcount;
  logic [PW-1:0] pos;
  logic [PW-1:0] dim;
  logic [PW-1:0] fill_pos;
  logic          pend_set;
  logic          sq_v;
  logic [SQW-1:0] sq;
  logic [NW-1:0] norm_acc;
  logic [NW-1:0] norm_sum;

  // pair loop
  logic [IW-1:0] pi;
  logic [IW-1:0] pj;
  logic [NW-1:0] ni;
  logic [NW-1:0] nj;
  logic [PW-1:0] d_iss;
  logic          rd_v;
  logic          mul_v;
  logic signed [2*ELEMENT_BITS-1:0] prod;
  logic signed [ACCW-1:0] acc;
  logic          neg;

  // serial arithmetic
  logic [PRW-1:0] mcand;
  logic [NW-1:0]  mplier;
  logic [PRW-1:0] pacc;
  logic [PRW-1:0] pacc_next;
  logic [PRW-1:0] mag2;
  logic [MCW-1:0] mcnt;
  logic [RW-1:0]  rem;
  logic [RW-1:0]  dsh;
  logic [QUOT_BITS-1:0] quo;
  logic [QUOT_BITS-1:0] quo_next;
  logic [QCW-1:0] qcnt;
  logic [QUOT_BITS-1:0] qv;
  logic [ROOT_BITS-1:0] root;
  logic [ROOT_BITS-1:0] sbit;
  logic [ROOT_BITS-1:0] trial;
  logic [2*ROOT_BITS-1:0] trial_sq;

  // top three
  logic [TOP_COUNT-1:0] best_v;
  logic [IW-1:0]        best_a   [TOP_COUNT];
  logic [IW-1:0]        best_b   [TOP_COUNT];
  logic signed [SIM_BITS-1:0] best_sim [TOP_COUNT];
  logic [TOP_COUNT-1:0] ins_new;
  logic [TOP_COUNT-1:0] ins_shift;
  logic [KW-1:0]        emit_k;

  // RAM ports
  logic                 vwe;
  logic [AW-1:0]        vwaddr;
  logic [ELEMENT_BITS-1:0] vwdata;
  logic [AW-1:0]        a_raddr;
  logic [AW-1:0]        b_raddr;
  logic [ELEMENT_BITS-1:0] a_rdata;
  logic [ELEMENT_BITS-1:0] b_rdata;
  logic                 nwe;
  logic [IW-1:0]        nraddr;
  logic [NW-1:0]        nrdata;

  // condition decode
  logic accept;
  logic store_en;
  logic [PW-1:0] pos_inc;
  logic fill_active;
  logic room;
  logic dot_done;
  logic zero_norm;
  logic [ACCW-1:0] mag_full;
  logic mul_done;
  logic div_done;
  logic sqrt_done;
  logic pair_last;
  logic row_last;
  logic emit_last;
  logic [ROOT_BITS-1:0] m17;
  logic signed [SIM_BITS-1:0] sim_cand;
  logic few_vectors;

  // ---------------------------------------------------------------- decode
  always_comb begin
    accept      = start && !busy;
    room        = (vcount < CW'(MAX_VECTORS));
    store_en    = room && (pos < PW'(MAX_DIMENSIONS)) &&
                  ((vcount == '0) || (pos < dim));
    pos_inc     = (pos < PW'(MAX_DIMENSIONS)) ? pos + PW'(1) : pos;
    fill_active = (vcount != '0) && room && (fill_pos < dim);
    norm_sum    = norm_acc + (sq_v ? NW'(sq) : NW'(0));
    few_vectors = (vcount < CW'(2));
    dot_done    = (d_iss == dim) && !rd_v && !mul_v;
    zero_norm   = (ni == '0) || (nj == '0);
    mag_full    = acc[ACCW-1] ? -acc : acc;
    pacc_next   = mplier[0] ? pacc + mcand : pacc;
    mul_done    = (mcnt == MCW'(NW - 1));
    quo_next    = (rem >= dsh) ? {quo[QUOT_BITS-2:0], 1'b1} : {quo[QUOT_BITS-2:0], 1'b0};
    div_done    = (qcnt == QCW'(QUOT_BITS - 1));
    trial       = root | sbit;
    trial_sq    = trial * trial;
    sqrt_done   = sbit[0];
    row_last    = ((CW+1)'(pj) + (CW+1)'(1)) == (CW+1)'(vcount);
    pair_last   = row_last && !(((IW+1)'(pi) + (IW+1)'(1)) < (IW+1)'(pj));
    emit_last   = few_vectors || (emit_k == KW'(TOP_COUNT - 1)) ||
                  !best_v[emit_k + KW'(1)];
  end

  // rounded Q1.15 similarity from the square root
  always_comb begin
    m17 = (root + ROOT_BITS'(1)) >> 1;
    if (neg) begin
      sim_cand = SIM_BITS'(-m17);
    end else if (m17 > ROOT_BITS'(SIM_MAX)) begin
      sim_cand = SIM_BITS'(SIM_MAX);
    end else begin
      sim_cand = SIM_BITS'(m17);
    end
  end

  // insertion point into the sorted top three, ties keep the older pair
  always_comb begin
    logic hit;
    hit       = 1'b0;
    ins_new   = '0;
    ins_shift = '0;
    for (int k = 0; k < TOP_COUNT; k++) begin
      if (hit) begin
        ins_shift[k] = 1'b1;
      end else if (!best_v[k] || (sim_cand > best_sim[k])) begin
        ins_new[k] = 1'b1;
        hit        = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:      if (accept && (item.vector_end || item.set_end)) state_next = S_FILL;
      S_FILL:      if (!fill_active) state_next = pend_set ? S_PAIR_INIT : S_LOAD;
      S_PAIR_INIT: state_next = few_vectors ? S_EMIT : S_RD_I;
      S_RD_I:      state_next = S_RD_J;
      S_RD_J:      state_next = S_CAP;
      S_CAP:       state_next = S_DOT;
      S_DOT:       if (dot_done) state_next = zero_norm ? S_OFFER : S_MUL_MAG;
      S_MUL_MAG:   if (mul_done) state_next = S_MUL_NORM;
      S_MUL_NORM:  if (mul_done) state_next = S_DIV;
      S_DIV:       if (div_done) state_next = S_SQRT;
      S_SQRT:      if (sqrt_done) state_next = S_OFFER;
      S_OFFER:     state_next = pair_last ? S_EMIT : S_RD_I;
      S_EMIT:      if (emit_last) state_next = S_LOAD;
      default:     state_next = S_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- RAM controls
  always_comb begin
    busy    = (state != S_LOAD);
    vwe     = ((state == S_LOAD) && accept && store_en) ||
              ((state == S_FILL) && fill_active);
    vwaddr  = (state == S_FILL) ? {vcount[IW-1:0], fill_pos[DW-1:0]}
                                : {vcount[IW-1:0], pos[DW-1:0]};
    vwdata  = (state == S_FILL) ? '0 : item.element_value;
    a_raddr = {pi, d_iss[DW-1:0]};
    b_raddr = {pj, d_iss[DW-1:0]};
    nwe     = (state == S_FILL) && !fill_active && room;
    nraddr  = (state == S_RD_I) ? pi : pj;
  end

  // two identical copies so both vectors of a pair read in one cycle
  pcst_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(VDEP)) u_vec_a (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  pcst_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(VDEP)) u_vec_b (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  pcst_ram #(.WIDTH(NW), .DEPTH(1 << IW)) u_norm (
    .clk(clk), .we(nwe), .waddr(vcount[IW-1:0]), .wdata(norm_sum),
    .raddr(nraddr), .rdata(nrdata)
  );

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      vcount   <= '0;
      pos      <= '0;
      dim      <= '0;
      pend_set <= 1'b0;
      sq_v     <= 1'b0;
      norm_acc <= '0;
      rd_v     <= 1'b0;
      mul_v    <= 1'b0;
      best_v   <= '0;
      strobe   <= 1'b0;
      emit_k   <= '0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      sq_v   <= 1'b0;
      if (sq_v) begin
        norm_acc <= norm_sum;
      end

      unique case (state)
        S_LOAD: begin
          if (accept) begin
            sq_v <= store_en;
            sq   <= SQW'(item.element_value * item.element_value);
            if (item.vector_end || item.set_end) begin
              fill_pos <= pos_inc;
              pend_set <= item.set_end;
              if (vcount == '0) begin
                dim <= pos_inc;
              end
            end else begin
              pos <= pos_inc;
            end
          end
        end

        // zero fill a short vector, then close it and store its norm
        S_FILL: begin
          if (fill_active) begin
            fill_pos <= fill_pos + PW'(1);
          end else begin
            if (room) begin
              vcount <= vcount + CW'(1);
            end
            norm_acc <= '0;
            pos      <= '0;
          end
        end

        S_PAIR_INIT: begin
          pi     <= '0;
          pj     <= IW'(1);
          best_v <= '0;
          emit_k <= '0;
        end

        S_RD_I: begin
        end

        S_RD_J: begin
          ni <= nrdata;
        end

        S_CAP: begin
          nj    <= nrdata;
          acc   <= '0;
          d_iss <= '0;
          rd_v  <= 1'b0;
          mul_v <= 1'b0;
        end

        // dot product: issue, multiply, accumulate
        S_DOT: begin
          rd_v  <= (d_iss < dim);
          if (d_iss < dim) begin
            d_iss <= d_iss + PW'(1);
          end
          prod  <= $signed(a_rdata) * $signed(b_rdata);
          mul_v <= rd_v;
          if (mul_v) begin
            acc <= acc + ACCW'(prod);
          end
          if (dot_done) begin
            neg    <= acc[ACCW-1];
            root   <= '0;
            mcand  <= PRW'(mag_full[NW-1:0]);
            mplier <= mag_full[NW-1:0];
            pacc   <= '0;
            mcnt   <= '0;
          end
        end

        // shift-add multiply, dot magnitude squared
        S_MUL_MAG: begin
          pacc   <= pacc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          mcnt   <= mcnt + MCW'(1);
          if (mul_done) begin
            mag2   <= pacc_next;
            mcand  <= PRW'(ni);
            mplier <= nj;
            pacc   <= '0;
            mcnt   <= '0;
          end
        end

        // shift-add multiply, product of the norms
        S_MUL_NORM: begin
          pacc   <= pacc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          mcnt   <= mcnt + MCW'(1);
          if (mul_done) begin
            rem  <= {mag2, FRAC_SHIFT'(0)};
            dsh  <= {pacc_next, FRAC_SHIFT'(0)};
            quo  <= '0;
            qcnt <= '0;
          end
        end

        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
          end
          dsh  <= dsh >> 1;
          quo  <= quo_next;
          qcnt <= qcnt + QCW'(1);
          if (div_done) begin
            qv   <= quo_next;
            root <= '0;
            sbit <= {1'b1, (ROOT_BITS-1)'(0)};
          end
        end

        // integer square root, one bit per cycle
        S_SQRT: begin
          if (trial_sq <= (2*ROOT_BITS)'(qv)) begin
            root <= trial;
          end
          sbit <= sbit >> 1;
        end

        S_OFFER: begin
          if (ins_new[0]) begin
            best_v[0]   <= 1'b1;
            best_a[0]   <= pi;
            best_b[0]   <= pj;
            best_sim[0] <= sim_cand;
          end
          for (int k = 1; k < TOP_COUNT; k++) begin
            if (ins_new[k]) begin
              best_v[k]   <= 1'b1;
              best_a[k]   <= pi;
              best_b[k]   <= pj;
              best_sim[k] <= sim_cand;
            end else if (ins_shift[k]) begin
              best_v[k]   <= best_v[k-1];
              best_a[k]   <= best_a[k-1];
              best_b[k]   <= best_b[k-1];
              best_sim[k] <= best_sim[k-1];
            end
          end
          if (!row_last) begin
            pj <= pj + IW'(1);
          end else if (!pair_last) begin
            pi <= pi + IW'(1);
            pj <= pi + IW'(2);
          end
        end

        S_EMIT: begin
          strobe <= 1'b1;
          if (few_vectors) begin
            result <= '{first_vector: '0, second_vector: '0, similarity: '0,
                        pair_found: 1'b0, last_result: 1'b1};
          end else begin
            result <= '{first_vector:  INDEX_BITS'(best_a[emit_k]),
                        second_vector: INDEX_BITS'(best_b[emit_k]),
                        similarity:    best_sim[emit_k],
                        pair_found:    1'b1,
                        last_result:   emit_last};
          end
          emit_k <= emit_k + KW'(1);
          if (emit_last) begin
            vcount   <= '0;
            pos      <= '0;
            dim      <= '0;
            pend_set <= 1'b0;
            best_v   <= '0;
          end
        end

        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  `PCST_ASSERT_IMP(a_last_clears_load, clk, rst, strobe && result.last_result, vcount == '0)
  `PCST_ASSERT_NXT(a_no_result_after_last, clk, rst, strobe && result.last_result, !strobe)
  `PCST_ASSERT_IMP(a_empty_is_last, clk, rst, strobe && !result.pair_found, result.last_result)
  `PCST_ASSERT_IMP(a_top_sorted, clk, rst, best_v[1], best_v[0] && (best_sim[0] >= best_sim[1]))
  `PCST_ASSERT_IMP(a_dot_bound, clk, rst, state == S_DOT, d_iss <= dim)

endmodule
